/* rtl/scrc_pkg.sv */
package scrc_pkg;

   // Field widths of one input word and one result word.
   localparam int SAMPLE_W = 16;
   localparam int CURRENT_W = 32;
   localparam int KEPT_W = 10;

   // Configuration registers.
   localparam int BURDEN_W = 20;
   localparam int TURNS_W = 14;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_BURDEN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TURNS = 1'd1;
   localparam logic [BURDEN_W-1:0] BURDEN_RESET = 20'd33000;
   localparam logic [TURNS_W-1:0] TURNS_RESET = 14'd2000;

   // One ADC step is 125 microvolts.
   localparam int STEP_UV = 125;
   localparam int STEP_W = 7;

   localparam int MAX_SAMPLES_DEFAULT = 512;

endpackage

/* rtl/scrc_if.sv */
interface scrc_req_if;
   import scrc_pkg::*;
   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic last_sample;
   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

interface scrc_rsp_if;
   import scrc_pkg::*;
   logic valid;
   logic ready;
   logic [CURRENT_W-1:0] current_milliamps;
   logic [KEPT_W-1:0] kept_count;
   logic overflow_flag;
   modport source (output valid, current_milliamps, kept_count, overflow_flag, input ready);
   modport sink (input valid, current_milliamps, kept_count, overflow_flag, output ready);
endinterface

/* rtl/scrc_ram.sv */
module scrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end

endmodule

/* rtl/sigma_clipped_rms_current.sv */
// Samples load at one word per cycle; ready is high whenever no window is being computed.
// After the word marked last, the result is formed by a pipelined scan of the sample RAM,
// a one-bit-per-cycle square root of 15 + CNT_W steps and a one-bit-per-cycle divider
// of 36 + CNT_W steps.
// Reset is synchronous and active high; it clears the window and loads the register
// defaults. The sample RAM is not cleared; only entries of the current window are read.
module sigma_clipped_rms_current #(
   parameter int MAX_SAMPLES = scrc_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   scrc_req_if.sink                           req_chan,
   scrc_rsp_if.source                         rsp_chan,
   input  logic                               csr_write,
   input  logic [scrc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scrc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import scrc_pkg::*;

   // Widths follow from the window size. All arithmetic is exact.
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int SUM_W = 16 + CNT_W;       // signed running sum
   localparam int SM_W = SUM_W - 1;         // its magnitude
   localparam int SQ_W = 30 + CNT_W;        // running sum of squares
   localparam int VAR_W = 30 + 2 * CNT_W;   // n*Q and S^2
   localparam int THR_W = VAR_W + 2;        // four times the scaled variance
   localparam int DEV_W = 17 + CNT_W;       // n*x - S, signed
   localparam int ROOT_W = VAR_W / 2;
   localparam int REM_W = ROOT_W + 3;
   localparam int TR_W = TURNS_W + STEP_W;
   localparam int NUM_W = TR_W + ROOT_W;
   localparam int DEN_W = CNT_W + BURDEN_W;
   localparam int IT_W = $clog2(NUM_W + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_VAR1  = 4'd1;
   localparam logic [3:0] S_VAR2  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_KEEP1 = 4'd4;
   localparam logic [3:0] S_KEEP2 = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_DIVST = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;

   // Registers and window accumulators.
   logic [BURDEN_W-1:0] burden_ff;
   logic [TURNS_W-1:0] turns_ff;
   logic [CNT_W-1:0] count_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0] sq_ff;
   logic dropped_ff;

   // Compute path registers.
   logic [VAR_W-1:0] nq_ff, s2_ff;
   logic [TR_W-1:0] tr_ff;
   logic [THR_W-1:0] thr_ff;
   logic var_zero_ff;
   logic [CNT_W-1:0] scan_addr_ff;
   logic s1_valid_ff, s2_valid_ff;
   logic signed [DEV_W-1:0] dev_ff;
   logic signed [SAMPLE_W-1:0] v_ff;
   logic [CNT_W-1:0] kept_ff;
   logic signed [SUM_W-1:0] ks_ff;
   logic [SQ_W-1:0] kq_ff;
   logic [DEN_W-1:0] den_ff;
   logic [VAR_W-1:0] d_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0] drem_ff;
   logic [IT_W-1:0] iter_ff;
   logic [CURRENT_W-1:0] cur_ff;
   logic sat_ff;

   // Result register.
   logic rsp_valid_ff;
   logic [CURRENT_W-1:0] rsp_cur_ff;
   logic [KEPT_W-1:0] rsp_kept_ff;
   logic rsp_ovf_ff;

   logic req_fire, store_ok, scan_issue, out_free;
   logic [SAMPLE_W-1:0] xmag;
   logic [31:0] xsq;
   logic [SAMPLE_W-1:0] vmag;
   logic [31:0] vsq;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SUM_W-1:0] sum_neg;
   logic [SM_W-1:0] smag;
   logic [VAR_W-1:0] nq_prod, s2_prod, var_val;
   logic signed [DEV_W-1:0] prod_nv, dev_val;
   logic [DEV_W-1:0] dev_neg;
   logic [DEV_W-2:0] dmag;
   logic [THR_W-1:0] dsq;
   logic keep_it;
   logic [SUM_W-1:0] ks_neg;
   logic [SM_W-1:0] ksmag;
   logic [VAR_W-1:0] kqk_prod, sk2_prod;
   logic [REM_W-1:0] rem_shift, rem_trial;
   logic [DEN_W:0] drem_shift;
   logic [CNT_W+KEPT_W-1:0] kept_wide;

   assign req_fire = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign store_ok = (count_ff < CNT_W'(MAX_SAMPLES));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Square of the incoming sample for the running sum of squares.
   assign xmag = req_chan.sample[SAMPLE_W-1] ? (~req_chan.sample + 16'd1) : req_chan.sample;
   assign xsq = xmag * xmag;

   // The RAM is written while loading and read in order during the scan.
   assign scan_issue = (state_ff == S_SCAN) && (scan_addr_ff < count_ff);

   scrc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock      (clock),
      .write_en   (req_fire && store_ok),
      .write_addr (count_ff[ADDR_W-1:0]),
      .write_data (req_chan.sample),
      .read_addr  (scan_addr_ff[ADDR_W-1:0]),
      .read_data  (ram_rdata)
   );

   // Scaled variance n*Q - S^2 of the whole window.
   assign sum_neg = -sum_ff;
   assign smag = sum_ff[SUM_W-1] ? sum_neg[SM_W-1:0] : sum_ff[SM_W-1:0];
   assign nq_prod = count_ff * sq_ff;
   assign s2_prod = smag * smag;
   assign var_val = (nq_ff > s2_ff) ? (nq_ff - s2_ff) : '0;

   // Scan stage one forms the scaled deviation n*x - S; stage two squares and tests it.
   assign prod_nv = $signed({1'b0, count_ff}) * $signed(ram_rdata);
   assign dev_val = prod_nv - DEV_W'(sum_ff);
   assign dev_neg = -dev_ff;
   assign dmag = dev_ff[DEV_W-1] ? dev_neg[DEV_W-2:0] : dev_ff[DEV_W-2:0];
   assign dsq = dmag * dmag;
   assign keep_it = var_zero_ff || (dsq < thr_ff);

   // Square of a kept sample for the kept sum of squares.
   assign vmag = v_ff[SAMPLE_W-1] ? (~v_ff + 16'd1) : v_ff;
   assign vsq = vmag * vmag;

   // Scaled variance of the kept samples.
   assign ks_neg = -ks_ff;
   assign ksmag = ks_ff[SUM_W-1] ? ks_neg[SM_W-1:0] : ks_ff[SM_W-1:0];
   assign kqk_prod = kept_ff * kq_ff;
   assign sk2_prod = ksmag * ksmag;

   // Square root takes two radicand bits per step; the divider one numerator bit.
   assign rem_shift = {rem_ff[REM_W-3:0], d_ff[VAR_W-1 -: 2]};
   assign rem_trial = REM_W'({root_ff, 2'b01});
   assign drem_shift = {drem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};

   assign kept_wide = {{KEPT_W{1'b0}}, kept_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.last_sample) begin
               state_in = S_VAR1;
            end
         end
         S_VAR1: state_in = S_VAR2;
         S_VAR2: state_in = S_SCAN;
         S_SCAN: begin
            if (!scan_issue && !s1_valid_ff && !s2_valid_ff) begin
               state_in = S_KEEP1;
            end
         end
         S_KEEP1: state_in = S_KEEP2;
         S_KEEP2: state_in = S_SQRT;
         S_SQRT: begin
            if (iter_ff == IT_W'(1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_DIVST;
         S_DIVST: begin
            if (quo_ff == '0 || den_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (iter_ff == IT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         burden_ff <= BURDEN_RESET;
         turns_ff <= TURNS_RESET;
         count_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         dropped_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_BURDEN: burden_ff <= csr_data[BURDEN_W-1:0];
               REG_TURNS: turns_ff <= csr_data[TURNS_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            if (store_ok) begin
               count_ff <= count_ff + CNT_W'(1);
               sum_ff <= sum_ff + SUM_W'(req_chan.sample);
               sq_ff <= sq_ff + SQ_W'(xsq);
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         s1_valid_ff <= scan_issue;
         s2_valid_ff <= s1_valid_ff;
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_DONE && out_free) begin
            // Hand over the result and open the next window.
            rsp_valid_ff <= 1'b1;
            count_ff <= '0;
            sum_ff <= '0;
            sq_ff <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   // Compute path.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_VAR1: begin
            nq_ff <= nq_prod;
            s2_ff <= s2_prod;
            tr_ff <= TR_W'(turns_ff * STEP_W'(STEP_UV));
            scan_addr_ff <= '0;
            kept_ff <= '0;
            ks_ff <= '0;
            kq_ff <= '0;
         end
         S_VAR2: begin
            thr_ff <= {var_val, 2'b00};
            var_zero_ff <= (var_val == '0);
         end
         S_SCAN: begin
            if (scan_issue) begin
               scan_addr_ff <= scan_addr_ff + CNT_W'(1);
            end
            if (s1_valid_ff) begin
               dev_ff <= dev_val;
               v_ff <= $signed(ram_rdata);
            end
            if (s2_valid_ff && keep_it) begin
               kept_ff <= kept_ff + CNT_W'(1);
               ks_ff <= ks_ff + SUM_W'(v_ff);
               kq_ff <= kq_ff + SQ_W'(vsq);
            end
         end
         S_KEEP1: begin
            nq_ff <= kqk_prod;
            s2_ff <= sk2_prod;
            den_ff <= kept_ff * burden_ff;
         end
         S_KEEP2: begin
            d_ff <= (nq_ff > s2_ff) ? (nq_ff - s2_ff) : '0;
            root_ff <= '0;
            rem_ff <= '0;
            iter_ff <= IT_W'(ROOT_W);
         end
         S_SQRT: begin
            d_ff <= {d_ff[VAR_W-3:0], 2'b00};
            iter_ff <= iter_ff - IT_W'(1);
            if (rem_shift >= rem_trial) begin
               rem_ff <= rem_shift - rem_trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         S_MUL: begin
            quo_ff <= tr_ff * root_ff;
         end
         S_DIVST: begin
            drem_ff <= '0;
            iter_ff <= IT_W'(NUM_W);
            cur_ff <= '0;
            sat_ff <= 1'b0;
            if (quo_ff != '0 && den_ff == '0) begin
               cur_ff <= '1;
               sat_ff <= 1'b1;
            end
         end
         S_DIV: begin
            iter_ff <= iter_ff - IT_W'(1);
            if (drem_shift >= {1'b0, den_ff}) begin
               drem_ff <= drem_shift - {1'b0, den_ff};
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_ff <= drem_shift;
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_kept_ff <= kept_wide[KEPT_W-1:0];
               rsp_cur_ff <= cur_ff;
               rsp_ovf_ff <= dropped_ff || sat_ff;
            end
         end
         default: ;
      endcase
      // The quotient is complete after the last divide step; clamp it to the field.
      if (state_ff == S_DIV && iter_ff == IT_W'(1)) begin
         if (quo_ff[NUM_W-2 -: (NUM_W-CURRENT_W)] != '0) begin
            cur_ff <= '1;
            sat_ff <= 1'b1;
         end else begin
            cur_ff <= {quo_ff[CURRENT_W-2:0], drem_shift >= {1'b0, den_ff}};
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.current_milliamps = rsp_cur_ff;
   assign rsp_chan.kept_count = rsp_kept_ff;
   assign rsp_chan.overflow_flag = rsp_ovf_ff;

endmodule

/* rtl/scrc_checker.sv */
module scrc_checker #(
   parameter int MAX_SAMPLES = scrc_pkg::MAX_SAMPLES_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_last_sample,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [scrc_pkg::CURRENT_W-1:0]     rsp_current_milliamps,
   input logic [scrc_pkg::KEPT_W-1:0]        rsp_kept_count
);

   localparam bit COUNT_FITS = (MAX_SAMPLES < 1024);

   // A result word stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // The end of a window starts the compute pass, which stops loading.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_sample |=> !req_ready)
      else $error("input still accepted after the last word of a window");

   // No more samples can pass than the store holds.
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && COUNT_FITS |-> rsp_kept_count <= 10'(MAX_SAMPLES))
      else $error("kept count exceeds the window capacity");

   // With no kept sample the current is zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && COUNT_FITS && rsp_kept_count == '0 |-> rsp_current_milliamps == '0)
      else $error("nonzero current with no kept sample");

endmodule

bind sigma_clipped_rms_current scrc_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .req_last_sample       (req_chan.last_sample),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_current_milliamps (rsp_chan.current_milliamps),
   .rsp_kept_count        (rsp_chan.kept_count)
);
